### rtl/blist_pkg.sv
// ----------------------------------------------------------------------------
// blist_pkg
// Shared constants for the bounded list: default depth, data width,
// request mode codes and result status codes.
// ----------------------------------------------------------------------------
package blist_pkg;

    // default list capacity and stored value width
    localparam int BLIST_DEPTH = 16;
    localparam int DATA_W      = 32;

    // request modes
    localparam logic [2:0] MODE_APPEND    = 3'd0;
    localparam logic [2:0] MODE_DEL_HEAD  = 3'd1;
    localparam logic [2:0] MODE_DEL_VALUE = 3'd2;
    localparam logic [2:0] MODE_DEL_TAIL  = 3'd3;
    localparam logic [2:0] MODE_DUMP      = 3'd4;

    // result status codes
    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_DUMP     = 3'd4;

endpackage

### rtl/blist_ram.sv
// ----------------------------------------------------------------------------
// blist_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module blist_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bounded_list_insert_delete_search.sv
// ----------------------------------------------------------------------------
// bounded_list_insert_delete_search
// Ordered list of up to DEPTH signed values, head in slot 0, held in one RAM.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; each result shows
// for one cycle on strobe and must be taken then, the receiver cannot stall.
// Append writes the RAM when taken, its result follows the next cycle and a new request
// can be taken at once. Delete tail reads the last entry and finishes in the
// search state. Delete head and delete by value make a search walk up to the
// match, then a compaction walk that moves every later entry one slot toward
// the head. Dump streams the entries from the head, one result per cycle.
// Every walk reads one entry per cycle through the single RAM read port.
// Modes 5 to 7 are ignored.
// ----------------------------------------------------------------------------
module bounded_list_insert_delete_search
    import blist_pkg::*;
#(
    parameter int DEPTH = BLIST_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [2:0]               mode,
    input  logic signed [DATA_W-1:0] value,
    output logic                     busy,
    output logic                     strobe,
    output logic [2:0]               status,
    output logic signed [DATA_W-1:0] value_res,
    output logic                     last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_DUMP
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [2:0]         mode_reg, mode_next;
    logic [DATA_W-1:0]  key_reg, key_next;
    logic [DATA_W-1:0]  hold_reg, hold_next;
    logic               strobe_reg, strobe_next;
    logic [2:0]         status_reg, status_next;
    logic [DATA_W-1:0]  value_res_reg, value_res_next;
    logic               last_reg, last_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [DATA_W-1:0]  ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [DATA_W-1:0]  ram_rdata;

    logic [CW-1:0]      idx_p1;
    logic [CW-1:0]      idx_p2;
    logic [CW-1:0]      start_idx;
    logic               match;

    // entry storage
    blist_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .ADDR_W(AW)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // walk index helpers and the shared compare
    assign idx_p1    = idx_reg + CW'(1);
    assign idx_p2    = idx_reg + CW'(2);
    assign start_idx = (mode == MODE_DEL_TAIL) ? (count_reg - CW'(1)) : '0;
    assign match     = (mode_reg != MODE_DEL_VALUE) || (ram_rdata == key_reg);

    // sequencer next-state logic
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        hold_next      = hold_reg;
        strobe_next    = 1'b0;
        status_next    = ST_DONE;
        value_res_next = '0;
        last_next      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg[AW-1:0];
        ram_wdata      = ram_rdata;
        ram_raddr      = idx_p1[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = start_idx[AW-1:0];
                if (start)
                begin
                    case (mode)
                        MODE_APPEND:
                        begin
                            strobe_next = 1'b1;
                            last_next   = 1'b1;
                            if (count_reg == CW'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                ram_waddr   = count_reg[AW-1:0];
                                ram_wdata   = value;
                                count_next  = count_reg + CW'(1);
                                status_next = ST_DONE;
                            end
                        end
                        MODE_DEL_HEAD, MODE_DEL_VALUE, MODE_DEL_TAIL:
                        begin
                            if (count_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                last_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                                mode_next  = mode;
                                key_next   = value;
                                idx_next   = start_idx;
                            end
                        end
                        MODE_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                last_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_DUMP;
                                idx_next   = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // compare the entry at idx, step on or start compaction
            S_SEARCH:
            begin
                if (match)
                begin
                    hold_next = ram_rdata;
                    if (idx_p1 == count_reg)
                    begin
                        count_next     = count_reg - CW'(1);
                        strobe_next    = 1'b1;
                        last_next      = 1'b1;
                        status_next    = ST_DONE;
                        value_res_next = ram_rdata;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
                else if (idx_p1 == count_reg)
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    status_next = ST_NOTFOUND;
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next = idx_p1;
                end
            end

            // move entry idx+1 into slot idx
            S_SHIFT:
            begin
                ram_raddr = idx_p2[AW-1:0];
                ram_we    = 1'b1;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = ram_rdata;
                idx_next  = idx_p1;
                if (idx_p2 == count_reg)
                begin
                    count_next     = count_reg - CW'(1);
                    strobe_next    = 1'b1;
                    last_next      = 1'b1;
                    status_next    = ST_DONE;
                    value_res_next = hold_reg;
                    state_next     = S_IDLE;
                end
            end

            // stream one entry per cycle
            S_DUMP:
            begin
                strobe_next    = 1'b1;
                status_next    = ST_DUMP;
                value_res_next = ram_rdata;
                last_next      = (idx_p1 == count_reg);
                if (idx_p1 == count_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_p1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            strobe_reg    <= 1'b0;
            idx_reg       <= '0;
            mode_reg      <= MODE_APPEND;
            key_reg       <= '0;
            hold_reg      <= '0;
            status_reg    <= ST_DONE;
            value_res_reg <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            strobe_reg    <= strobe_next;
            idx_reg       <= idx_next;
            mode_reg      <= mode_next;
            key_reg       <= key_next;
            hold_reg      <= hold_next;
            status_reg    <= status_next;
            value_res_reg <= value_res_next;
            last_reg      <= last_next;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign strobe    = strobe_reg;
    assign status    = status_reg;
    assign value_res = value_res_reg;
    assign last      = last_reg;

    // count never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("list count above capacity");

    // an accepted append reports in the next cycle
    a_append_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_APPEND) |=> (strobe && last))
        else $error("append without a result");

    // the final result of a request leaves the block idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> !busy)
        else $error("busy after final result");

    // only a dump produces non-final results, and only while busy
    a_nonlast_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> (busy && status == ST_DUMP))
        else $error("non-final result outside a dump");

    // compaction only moves stored entries
    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (idx_p1 < count_reg))
        else $error("compaction beyond the tail");

endmodule

### tb/tb_bounded_list_insert_delete_search.sv
// ----------------------------------------------------------------------------
// tb_bounded_list_insert_delete_search
// Self-checking bench for the bounded list. Requests go in through the
// start/busy command handshake. A list model in the bench predicts the status,
// value and last flag of every result. A checker compares each strobed result
// with the oldest prediction. Directed tests cover the empty list, extreme
// values, every delete mode, the full list and the ignored modes. A random
// phase then mixes fill and drain bursts with single requests and idle gaps.
// ----------------------------------------------------------------------------
module tb_bounded_list_insert_delete_search;
    import blist_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH    = BLIST_DEPTH;
    localparam int RANDOM_ITEMS  = 370;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 100;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } list_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic [2:0]               mode;
    logic signed [DATA_W-1:0] value;
    logic                     busy;
    logic                     strobe;
    logic [2:0]               status;
    logic signed [DATA_W-1:0] value_res;
    logic                     last;

    // list model state
    logic signed [DATA_W-1:0] list_slots [LIST_DEPTH];
    int                       list_count;

    list_result_t             pending_results [$];
    int                       error_count;
    int                       cycle_count;
    int                       requests_sent;
    bit                       idle_enable;

    bounded_list_insert_delete_search #(
        .DEPTH(LIST_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .mode     (mode),
        .value    (value),
        .busy     (busy),
        .strobe   (strobe),
        .status   (status),
        .value_res(value_res),
        .last     (last)
    );

    // clock, 10 ns period
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    // queue one predicted result
    function automatic void push_result(input logic [2:0] st,
                                        input logic signed [DATA_W-1:0] v,
                                        input logic lst);
        list_result_t r;
        r.status = st;
        r.value  = v;
        r.last   = lst;
        pending_results.push_back(r);
    endfunction

    // remove one slot, later entries move toward the head
    function automatic logic signed [DATA_W-1:0] remove_slot(input int pos);
        logic signed [DATA_W-1:0] v;
        v = list_slots[pos];
        for (int i = pos; i + 1 < list_count; i++)
            list_slots[i] = list_slots[i + 1];
        list_count--;
        return v;
    endfunction

    // list model: expected results of one accepted request
    task automatic predict_request(input logic [2:0] req_mode,
                                   input logic signed [DATA_W-1:0] req_value);
        int pos;
        pos = -1;
        case (req_mode)
            MODE_APPEND:
            begin
                if (list_count >= LIST_DEPTH)
                    push_result(ST_FULL, '0, 1'b1);
                else
                begin
                    list_slots[list_count] = req_value;
                    list_count++;
                    push_result(ST_DONE, '0, 1'b1);
                end
            end
            MODE_DEL_HEAD:
            begin
                if (list_count == 0)
                    push_result(ST_EMPTY, '0, 1'b1);
                else
                    push_result(ST_DONE, remove_slot(0), 1'b1);
            end
            MODE_DEL_VALUE:
            begin
                if (list_count == 0)
                    push_result(ST_EMPTY, '0, 1'b1);
                else
                begin
                    for (int i = 0; i < list_count && pos < 0; i++)
                        if (list_slots[i] == req_value)
                            pos = i;
                    if (pos < 0)
                        push_result(ST_NOTFOUND, '0, 1'b1);
                    else
                        push_result(ST_DONE, remove_slot(pos), 1'b1);
                end
            end
            MODE_DEL_TAIL:
            begin
                if (list_count == 0)
                    push_result(ST_EMPTY, '0, 1'b1);
                else
                    push_result(ST_DONE, remove_slot(list_count - 1), 1'b1);
            end
            MODE_DUMP:
            begin
                if (list_count == 0)
                    push_result(ST_EMPTY, '0, 1'b1);
                else
                    for (int i = 0; i < list_count; i++)
                        push_result(ST_DUMP, list_slots[i], i + 1 == list_count);
            end
            default:
            begin
                // undefined modes leave the list alone
            end
        endcase
    endtask

    // one request transfer, with a random idle gap ahead of it
    task automatic send_request(input logic [2:0] req_mode,
                                input logic signed [DATA_W-1:0] req_value);
        int gap;
        gap = idle_enable ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        mode  <= req_mode;
        value <= req_value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_request(req_mode, req_value);
        requests_sent++;
    endtask

    // random value: small pool for duplicates, extremes, or any 32 bits
    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 7);
        if (r < 3)
            return $signed($urandom_range(0, 7)) - 4;
        else if (r == 3)
            return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
        else
            return $urandom;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        list_result_t exp_r;
        if (rst_n && strobe === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t unexpected result: status %0d value %0d last %0b",
                             $time, status, value_res, last);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.status)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t status mismatch: expected %0d actual %0d",
                                 $time, exp_r.status, status);
                end
                if (value_res !== exp_r.value)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t value_res mismatch: expected %0d actual %0d",
                                 $time, exp_r.value, value_res);
                end
                if (last !== exp_r.last)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t last mismatch: expected %0b actual %0b",
                                 $time, exp_r.last, last);
                end
            end
        end
    end

    // every delete mode and dump on an empty list
    task automatic test_empty_list();
        send_request(MODE_DEL_HEAD, 32'sd0);
        send_request(MODE_DEL_TAIL, 32'sd0);
        send_request(MODE_DEL_VALUE, 32'sh7fff_ffff);
        send_request(MODE_DUMP, 32'sd0);
    endtask

    // extreme values, each delete mode, value not found
    task automatic test_delete_modes();
        send_request(MODE_APPEND, 32'sh8000_0000);
        send_request(MODE_APPEND, 32'sh7fff_ffff);
        send_request(MODE_APPEND, -32'sd1);
        send_request(MODE_APPEND, 32'sh7fff_ffff);
        send_request(MODE_DUMP, 32'sd0);
        send_request(MODE_DEL_VALUE, 32'sd0);
        send_request(MODE_DEL_VALUE, 32'sh7fff_ffff);
        send_request(MODE_DEL_HEAD, 32'sd0);
        send_request(MODE_DEL_TAIL, 32'sd0);
        send_request(MODE_DUMP, 32'sd0);
        send_request(MODE_DEL_HEAD, 32'sd0);
    endtask

    // undefined modes are ignored
    task automatic test_ignored_modes();
        send_request(3'd5, 32'sh5555_5555);
        send_request(3'd6, 32'shaaaa_aaaa);
        send_request(3'd7, -32'sd1);
        send_request(MODE_DUMP, 32'sd0);
    endtask

    // fill to capacity, append to full, dump every slot
    task automatic test_full_list();
        while (list_count < LIST_DEPTH)
            send_request(MODE_APPEND, pick_value());
        send_request(MODE_APPEND, 32'sd1);
        send_request(MODE_DUMP, 32'sd0);
    endtask

    // random mix of bursts and single requests
    task automatic test_random_traffic();
        int r;
        int target;
        logic signed [DATA_W-1:0] v;
        while (requests_sent < RANDOM_ITEMS)
        begin
            // change idle behavior now and then, some stretches run back to back
            if ($urandom_range(0, 29) == 0)
                idle_enable = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 3)
                send_request(3'($urandom_range(5, 7)), $urandom);
            else if (r < 8)
            begin
                // fill burst up to full, with an extra append or two
                target = LIST_DEPTH + $urandom_range(1, 2);
                for (int i = list_count; i < target; i++)
                    send_request(MODE_APPEND, pick_value());
                send_request(MODE_DUMP, $urandom);
            end
            else if (r < 12)
            begin
                // drain burst down to empty and one past it
                while (list_count > 0)
                    send_request(3'($urandom_range(0, 1) ? MODE_DEL_HEAD : MODE_DEL_TAIL),
                                 $urandom);
                send_request(3'($urandom_range(1, 3)), $urandom);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    send_request(MODE_APPEND, pick_value());
                else if (r < 52)
                    send_request(MODE_DEL_HEAD, $urandom);
                else if (r < 74)
                begin
                    if (list_count > 0 && $urandom_range(0, 9) < 7)
                        v = list_slots[$urandom_range(0, list_count - 1)];
                    else
                        v = pick_value();
                    send_request(MODE_DEL_VALUE, v);
                end
                else if (r < 86)
                    send_request(MODE_DEL_TAIL, $urandom);
                else
                    send_request(MODE_DUMP, $urandom);
            end
        end
    endtask

    initial
    begin
        start         = 1'b0;
        mode          = MODE_APPEND;
        value         = '0;
        rst_n         = 1'b0;
        list_count    = 0;
        error_count   = 0;
        cycle_count   = 0;
        requests_sent = 0;
        idle_enable   = 1'b1;
        for (int i = 0; i < LIST_DEPTH; i++)
            list_slots[i] = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_delete_modes();
        test_ignored_modes();
        test_full_list();
        test_random_traffic();

        @(negedge clk);
        start <= 1'b0;
        // drain outstanding results, then watch for stray ones
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LIST_DEPTH + 4) @(posedge clk);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
